/* sv/stl_pkg.sv */
// Shared types, codes and keyword ROM for the source token lexer.
package stl_pkg;

    // Result kinds
    localparam logic [3:0] KIND_IDENT   = 4'd0;
    localparam logic [3:0] KIND_KEYWORD = 4'd1;
    localparam logic [3:0] KIND_NUMBER  = 4'd2;
    localparam logic [3:0] KIND_CLOSE   = 4'd3;
    localparam logic [3:0] KIND_OP      = 4'd4;
    localparam logic [3:0] KIND_SYMBOL  = 4'd5;
    localparam logic [3:0] KIND_END     = 4'd6;
    localparam logic [3:0] KIND_CHAR    = 4'd7;
    localparam logic [3:0] KIND_ERROR   = 4'd8;

    // Error codes
    localparam logic ERR_UNTERMINATED = 1'b0;
    localparam logic ERR_BAD_CHAR     = 1'b1;

    // Operator and symbol codes
    localparam logic [4:0] P_NEQ_SLASH = 5'd0;
    localparam logic [4:0] P_EQ_EQ     = 5'd1;
    localparam logic [4:0] P_BANG_EQ   = 5'd2;
    localparam logic [4:0] P_LE        = 5'd3;
    localparam logic [4:0] P_GE        = 5'd4;
    localparam logic [4:0] P_ARROW     = 5'd5;
    localparam logic [4:0] P_PLUS      = 5'd6;
    localparam logic [4:0] P_MINUS     = 5'd7;
    localparam logic [4:0] P_STAR      = 5'd8;
    localparam logic [4:0] P_SLASH     = 5'd9;
    localparam logic [4:0] P_ASSIGN    = 5'd10;
    localparam logic [4:0] P_LT        = 5'd11;
    localparam logic [4:0] P_GT        = 5'd12;
    localparam logic [4:0] P_LPAREN    = 5'd13;
    localparam logic [4:0] P_RPAREN    = 5'd14;
    localparam logic [4:0] P_LBRACE    = 5'd15;
    localparam logic [4:0] P_RBRACE    = 5'd16;
    localparam logic [4:0] P_SEMI      = 5'd17;
    localparam logic [4:0] P_COMMA     = 5'd18;

    // Step records held between front and back
    localparam int QUEUE_DEPTH = 4;

    localparam logic [62:0] NUM_MAX = {63{1'b1}};

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [3:0]  kwi;
        logic [4:0]  punct;
        logic [62:0] num;
        logic [7:0]  ch;
        logic        err;
    } stl_result_t;

    // One accepted input item: 1..3 results
    typedef struct packed {
        logic [1:0]             count;
        stl_result_t [2:0]      res;
    } stl_record_t;

    // Keyword ROM: UTF-8 text, right aligned, first byte highest
    localparam int ROM_ENTRIES = 12;
    localparam int ROM_ROW     = 28;

    localparam logic [7:0] KW_LEN [ROM_ENTRIES] = '{
        8'd27, 8'd10, 8'd2, 8'd10, 8'd12, 8'd19, 8'd25, 8'd17, 8'd23, 8'd13, 8'd17, 8'd7
    };

    localparam logic [8*ROM_ROW-1:0] KW_TEXT [ROM_ENTRIES] = '{
        224'hD0B8_D181_D0BF_2E_D0BA_D0BE_D0BC_D0B0_D0BD_D0B4_D183_2E_70_72_69_6E_74,
        224'hD0BF_D183_D181_D182_D18C,
        224'hD0B2,
        224'hD182_D0B0_D0BA_D0BE_D0BC,
        224'hD181_D0BB_D183_D187_D0B0_D0B5,
        224'hD0B8_D0BD_D0B0_D187_D0B5_2E_D0B5_D181_D0BB_D0B8,
        224'hD0BF_D0BE_D0B2_D182_D0BE_D180_D18F_D182_D18C_2E_D180_D0B0_D0B7,
        224'hD0B8_D181_D182_D0B8_D0BD_D0B0_2E_D0BE_D0BA,
        224'hD0BB_D0BE_D0B6_D18C_2E_D0BF_D0B0_D0B4_D0B5_D0BD_D0B8_D0B5,
        224'hD0B8_2E_D182_D0B0_D0BA_D0B6_D0B5,
        224'hD0B8_D0BB_D0B8_2E_D0B8_D0BD_D0B0_D187_D0B5,
        224'hD0BD_D0B5_2E_D0B0
    };

    // Byte k of keyword i; caller keeps k below the keyword length
    function automatic logic [7:0] kw_byte(input int i, input int k);
        kw_byte = KW_TEXT[i][8*(int'(KW_LEN[i]) - 1 - k) +: 8];
    endfunction

    function automatic stl_result_t mk_res(input logic [3:0] kind, input logic [31:0] start,
                                           input logic [31:0] len, input logic [3:0] kwi,
                                           input logic [4:0] punct, input logic [62:0] num,
                                           input logic [7:0] ch, input logic err);
        stl_result_t r;
        r.kind  = kind;
        r.start = start;
        r.len   = len;
        r.kwi   = kwi;
        r.punct = punct;
        r.num   = num;
        r.ch    = ch;
        r.err   = err;
        mk_res  = r;
    endfunction

endpackage

/* sv/stl_front.sv */
// Front end: lexer state machine, one source byte or end command per cycle when in_fire is set, builds step records.
module stl_front #(
    parameter int POS_WIDTH         = 32,
    parameter int KEYWORD_COUNT     = 12,
    parameter int MAX_KEYWORD_BYTES = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic                 in_cmd,
    input  logic [7:0]           in_byte,
    output logic                 push,
    output stl_pkg::stl_record_t push_rec
);

    localparam int NKW = (KEYWORD_COUNT < stl_pkg::ROM_ENTRIES) ? KEYWORD_COUNT
                                                                : stl_pkg::ROM_ENTRIES;
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    // No two-byte operator formed
    localparam logic [4:0] TWO_NONE = 5'd31;

    // Lexer modes
    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_IDENT  = 3'd1;
    localparam logic [2:0] M_NUMBER = 3'd2;
    localparam logic [2:0] M_STRING = 3'd3;
    localparam logic [2:0] M_OP_ONE = 3'd4;
    localparam logic [2:0] M_OP_TWO = 3'd5;

    logic [2:0]           mode_reg, mode_next;
    logic [7:0]           held_reg, held_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [POS_WIDTH-1:0] begin_reg, begin_next;
    logic [31:0]          count_reg, count_next;
    logic [62:0]          acc_reg, acc_next;
    logic [NKW-1:0]       cand_reg, cand_next;
    logic                 esc_reg, esc_next;
    logic                 sink_reg, sink_next;

    // Candidates that still match after byte b at offset k
    function automatic logic [NKW-1:0] keep(input logic [NKW-1:0] mask,
                                            input logic [31:0] k, input logic [7:0] b);
        logic [NKW-1:0] r;
        r = '0;
        for (int i = 0; i < NKW; i++) begin
            if (mask[i] && k < 32'(stl_pkg::KW_LEN[i]) && k < 32'(MAX_KEYWORD_BYTES)
                && k < 32'(stl_pkg::ROM_ROW)
                && stl_pkg::kw_byte(i, int'(k[4:0])) == b) begin
                r[i] = 1'b1;
            end
        end
        keep = r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b[7];
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = b >= "0" && b <= "9";
    endfunction

    // Single-byte operator code, valid flag in bit 5
    function automatic logic [5:0] op_code(input logic [7:0] b);
        unique case (b)
            "+":     op_code = {1'b1, stl_pkg::P_PLUS};
            "-":     op_code = {1'b1, stl_pkg::P_MINUS};
            "*":     op_code = {1'b1, stl_pkg::P_STAR};
            "/":     op_code = {1'b1, stl_pkg::P_SLASH};
            "=":     op_code = {1'b1, stl_pkg::P_ASSIGN};
            "<":     op_code = {1'b1, stl_pkg::P_LT};
            ">":     op_code = {1'b1, stl_pkg::P_GT};
            default: op_code = 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] sym_code(input logic [7:0] b);
        unique case (b)
            "(":     sym_code = {1'b1, stl_pkg::P_LPAREN};
            ")":     sym_code = {1'b1, stl_pkg::P_RPAREN};
            "{":     sym_code = {1'b1, stl_pkg::P_LBRACE};
            "}":     sym_code = {1'b1, stl_pkg::P_RBRACE};
            ";":     sym_code = {1'b1, stl_pkg::P_SEMI};
            ",":     sym_code = {1'b1, stl_pkg::P_COMMA};
            default: sym_code = 6'd0;
        endcase
    endfunction

    // Next-state and result assembly for one item
    always_comb begin
        logic [1:0]            n;
        stl_pkg::stl_result_t [2:0] res;
        logic                  fresh;
        logic                  found;
        logic [5:0]            oc;
        logic [5:0]            sc;
        logic [4:0]            two;
        logic [66:0]           t;
        logic [7:0]            ch;
        logic [POS_WIDTH-1:0]  p;

        n          = 2'd0;
        res        = '0;
        fresh      = 1'b0;
        found      = 1'b0;
        two        = TWO_NONE;
        t          = '0;
        ch         = '0;
        p          = pos_reg;
        mode_next  = mode_reg;
        held_next  = held_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        cand_next  = cand_reg;
        esc_next   = esc_reg;
        sink_next  = sink_reg;
        oc         = op_code(held_reg);
        sc         = sym_code(in_byte);

        if (in_fire) begin
            if (in_cmd || in_byte == 8'd0) begin
                // Flush pending token, then end
                if (!sink_reg) begin
                    unique case (mode_reg)
                        M_IDENT: begin
                            for (int i = 0; i < NKW; i++) begin
                                if (!found && cand_reg[i]
                                    && 32'(stl_pkg::KW_LEN[i]) == count_reg) begin
                                    found = 1'b1;
                                    res[n] = stl_pkg::mk_res(stl_pkg::KIND_KEYWORD,
                                        32'(begin_reg), count_reg, 4'(i), '0, '0, '0, '0);
                                end
                            end
                            if (!found) begin
                                res[n] = stl_pkg::mk_res(stl_pkg::KIND_IDENT, 32'(begin_reg),
                                    count_reg, '0, '0, '0, '0, '0);
                            end
                            n = n + 2'd1;
                        end
                        M_NUMBER: begin
                            res[n] = stl_pkg::mk_res(stl_pkg::KIND_NUMBER, 32'(begin_reg),
                                count_reg, '0, '0, acc_reg, '0, '0);
                            n = n + 2'd1;
                        end
                        M_STRING: begin
                            res[n] = stl_pkg::mk_res(stl_pkg::KIND_ERROR, 32'(begin_reg),
                                count_reg, '0, '0, '0, '0, stl_pkg::ERR_UNTERMINATED);
                            n = n + 2'd1;
                        end
                        M_OP_ONE: begin
                            if (oc[5]) begin
                                res[n] = stl_pkg::mk_res(stl_pkg::KIND_OP, 32'(begin_reg),
                                    32'd1, '0, oc[4:0], '0, '0, '0);
                            end else begin
                                res[n] = stl_pkg::mk_res(stl_pkg::KIND_ERROR, 32'(begin_reg),
                                    32'd1, '0, '0, '0, '0, stl_pkg::ERR_BAD_CHAR);
                            end
                            n = n + 2'd1;
                        end
                        M_OP_TWO: begin
                            res[n] = stl_pkg::mk_res(stl_pkg::KIND_OP, 32'(begin_reg), 32'd1,
                                '0, stl_pkg::P_ASSIGN, '0, '0, '0);
                            n = n + 2'd1;
                            res[n] = stl_pkg::mk_res(stl_pkg::KIND_OP,
                                32'((begin_reg == POS_MAX) ? begin_reg : begin_reg + 1'b1),
                                32'd1, '0, stl_pkg::P_SLASH, '0, '0, '0);
                            n = n + 2'd1;
                        end
                        default: ;
                    endcase
                end
                res[n] = stl_pkg::mk_res(stl_pkg::KIND_END, 32'(pos_reg), '0, '0, '0, '0,
                                         '0, '0);
                n = n + 2'd1;
                mode_next  = M_IDLE;
                held_next  = '0;
                pos_next   = '0;
                begin_next = '0;
                count_next = '0;
                acc_next   = '0;
                cand_next  = '0;
                esc_next   = 1'b0;
                sink_next  = 1'b0;
            end else begin
                pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
                if (!sink_reg) begin
                    unique case (mode_reg)
                        M_IDENT: begin
                            if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == ".") begin
                                cand_next  = keep(cand_reg, count_reg, in_byte);
                                count_next = (&count_reg) ? count_reg : count_reg + 32'd1;
                            end else begin
                                for (int i = 0; i < NKW; i++) begin
                                    if (!found && cand_reg[i]
                                        && 32'(stl_pkg::KW_LEN[i]) == count_reg) begin
                                        found = 1'b1;
                                        res[n] = stl_pkg::mk_res(stl_pkg::KIND_KEYWORD,
                                            32'(begin_reg), count_reg, 4'(i), '0, '0, '0, '0);
                                    end
                                end
                                if (!found) begin
                                    res[n] = stl_pkg::mk_res(stl_pkg::KIND_IDENT,
                                        32'(begin_reg), count_reg, '0, '0, '0, '0, '0);
                                end
                                n = n + 2'd1;
                                fresh = 1'b1;
                            end
                        end
                        M_NUMBER: begin
                            if (is_digit(in_byte)) begin
                                t = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                                    + 67'(in_byte - 8'h30);
                                acc_next   = (t > 67'(stl_pkg::NUM_MAX)) ? stl_pkg::NUM_MAX
                                                                         : t[62:0];
                                count_next = (&count_reg) ? count_reg : count_reg + 32'd1;
                            end else begin
                                res[n] = stl_pkg::mk_res(stl_pkg::KIND_NUMBER, 32'(begin_reg),
                                    count_reg, '0, '0, acc_reg, '0, '0);
                                n = n + 2'd1;
                                fresh = 1'b1;
                            end
                        end
                        M_STRING: begin
                            if (esc_reg) begin
                                esc_next = 1'b0;
                                ch = (in_byte == "n") ? 8'd10 : ((in_byte == "t") ? 8'd9
                                                                                  : in_byte);
                                res[n] = stl_pkg::mk_res(stl_pkg::KIND_CHAR,
                                    32'(pos_reg - 1'b1), 32'd1, '0, '0, '0, ch, '0);
                                n = n + 2'd1;
                                count_next = (&count_reg) ? count_reg : count_reg + 32'd1;
                            end else if (in_byte == "\"") begin
                                res[n] = stl_pkg::mk_res(stl_pkg::KIND_CLOSE, 32'(begin_reg),
                                    count_reg, '0, '0, '0, '0, '0);
                                n = n + 2'd1;
                                mode_next = M_IDLE;
                            end else if (in_byte == "\\") begin
                                esc_next = 1'b1;
                            end else begin
                                res[n] = stl_pkg::mk_res(stl_pkg::KIND_CHAR, 32'(pos_reg),
                                    32'd1, '0, '0, '0, in_byte, '0);
                                n = n + 2'd1;
                                count_next = (&count_reg) ? count_reg : count_reg + 32'd1;
                            end
                        end
                        M_OP_ONE: begin
                            if (held_reg == "=" && in_byte == "/") begin
                                mode_next = M_OP_TWO;
                            end else begin
                                if (in_byte == "=") begin
                                    unique case (held_reg)
                                        "=":     two = stl_pkg::P_EQ_EQ;
                                        "!":     two = stl_pkg::P_BANG_EQ;
                                        "<":     two = stl_pkg::P_LE;
                                        ">":     two = stl_pkg::P_GE;
                                        default: two = TWO_NONE;
                                    endcase
                                end else if (in_byte == ">" && held_reg == "=") begin
                                    two = stl_pkg::P_ARROW;
                                end
                                mode_next = M_IDLE;
                                if (two != TWO_NONE) begin
                                    res[n] = stl_pkg::mk_res(stl_pkg::KIND_OP, 32'(begin_reg),
                                        32'd2, '0, two, '0, '0, '0);
                                    n = n + 2'd1;
                                end else if (oc[5]) begin
                                    res[n] = stl_pkg::mk_res(stl_pkg::KIND_OP, 32'(begin_reg),
                                        32'd1, '0, oc[4:0], '0, '0, '0);
                                    n = n + 2'd1;
                                    fresh = 1'b1;
                                end else begin
                                    // lone '!': error, this byte is dropped
                                    res[n] = stl_pkg::mk_res(stl_pkg::KIND_ERROR,
                                        32'(begin_reg), 32'd1, '0, '0, '0, '0,
                                        stl_pkg::ERR_BAD_CHAR);
                                    n = n + 2'd1;
                                    sink_next = 1'b1;
                                end
                            end
                        end
                        M_OP_TWO: begin
                            mode_next = M_IDLE;
                            if (in_byte == "=") begin
                                res[n] = stl_pkg::mk_res(stl_pkg::KIND_OP, 32'(begin_reg),
                                    32'd3, '0, stl_pkg::P_NEQ_SLASH, '0, '0, '0);
                                n = n + 2'd1;
                            end else begin
                                res[n] = stl_pkg::mk_res(stl_pkg::KIND_OP, 32'(begin_reg),
                                    32'd1, '0, stl_pkg::P_ASSIGN, '0, '0, '0);
                                n = n + 2'd1;
                                res[n] = stl_pkg::mk_res(stl_pkg::KIND_OP,
                                    32'((begin_reg == POS_MAX) ? begin_reg : begin_reg + 1'b1),
                                    32'd1, '0, stl_pkg::P_SLASH, '0, '0, '0);
                                n = n + 2'd1;
                                fresh = 1'b1;
                            end
                        end
                        default: fresh = 1'b1;
                    endcase
                end

                // Start a token at this byte
                if (fresh) begin
                    mode_next = M_IDLE;
                    oc = op_code(in_byte);
                    if (in_byte == " " || in_byte == 8'd9 || in_byte == 8'd10
                        || in_byte == 8'd13) begin
                        mode_next = M_IDLE;
                    end else if (is_alpha(in_byte)) begin
                        mode_next  = M_IDENT;
                        begin_next = p;
                        count_next = 32'd1;
                        cand_next  = keep({NKW{1'b1}}, 32'd0, in_byte);
                    end else if (is_digit(in_byte)) begin
                        mode_next  = M_NUMBER;
                        begin_next = p;
                        count_next = 32'd1;
                        acc_next   = 63'(in_byte - 8'h30);
                    end else if (in_byte == "\"") begin
                        mode_next  = M_STRING;
                        begin_next = p;
                        count_next = 32'd0;
                        esc_next   = 1'b0;
                    end else if (in_byte == "=" || in_byte == "<" || in_byte == ">"
                                 || in_byte == "!") begin
                        mode_next  = M_OP_ONE;
                        held_next  = in_byte;
                        begin_next = p;
                    end else if (oc[5]) begin
                        res[n] = stl_pkg::mk_res(stl_pkg::KIND_OP, 32'(p), 32'd1, '0,
                                                 oc[4:0], '0, '0, '0);
                        n = n + 2'd1;
                    end else if (sc[5]) begin
                        res[n] = stl_pkg::mk_res(stl_pkg::KIND_SYMBOL, 32'(p), 32'd1, '0,
                                                 sc[4:0], '0, '0, '0);
                        n = n + 2'd1;
                    end else begin
                        res[n] = stl_pkg::mk_res(stl_pkg::KIND_ERROR, 32'(p), 32'd1, '0,
                                                 '0, '0, '0, stl_pkg::ERR_BAD_CHAR);
                        n = n + 2'd1;
                        sink_next = 1'b1;
                    end
                end
            end
        end

        push           = in_fire && (n != 2'd0);
        push_rec.count = n;
        push_rec.res   = res;
    end

    // Lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            held_reg  <= '0;
            pos_reg   <= '0;
            begin_reg <= '0;
            count_reg <= '0;
            acc_reg   <= '0;
            cand_reg  <= '0;
            esc_reg   <= 1'b0;
            sink_reg  <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            cand_reg  <= cand_next;
            esc_reg   <= esc_next;
            sink_reg  <= sink_next;
        end
    end

endmodule

/* sv/stl_queue.sv */
// Step record queue between the lexer front end and the result back end.
module stl_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  stl_pkg::stl_record_t push_rec,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_valid,
    output stl_pkg::stl_record_t head_rec
);

    localparam int AW = $clog2(stl_pkg::QUEUE_DEPTH);

    stl_pkg::stl_record_t mem_reg [stl_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign full       = cnt_reg == (AW+1)'(stl_pkg::QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_rec   = mem_reg[rd_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(stl_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

/* sv/stl_back.sv */
// Back end: unpacks step records into single result transactions.
module stl_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  stl_pkg::stl_record_t head_rec,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [151:0]         m_tdata,
    output logic [3:0]           m_tuser,
    output logic                 m_tlast
);

    logic [1:0]           idx_reg;
    logic                 ov_reg;
    stl_pkg::stl_result_t out_reg;
    logic                 last_reg;
    logic                 load;
    logic                 is_last;

    assign load    = !ov_reg || m_tready;
    assign is_last = idx_reg == head_rec.count - 2'd1;
    assign pop     = load && head_valid && is_last;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg  <= 1'b0;
            idx_reg <= '0;
        end else if (load) begin
            ov_reg <= head_valid;
            if (head_valid) begin
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && head_valid) begin
            out_reg  <= head_rec.res[idx_reg];
            last_reg <= is_last;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = last_reg;
    assign m_tdata  = {7'd0, out_reg.err, out_reg.ch, out_reg.num, out_reg.punct,
                       out_reg.kwi, out_reg.len, out_reg.start};

endmodule

/* sv/source_token_lexer_unit.sv */
// Top level of the streaming source token lexer.
// Takes one source byte or end command per cycle while the four-entry step queue has room;
// each item yields zero to three results, which leave one per cycle through the output
// register, so throughput is one item per cycle unless items average more than one result
// or the sink stalls. The lexer state machine builds each item's record combinationally;
// the record is written into the step queue, then moves from its head into the output register.
module source_token_lexer_unit #(
    parameter int POS_WIDTH         = 32,
    parameter int KEYWORD_COUNT     = 12,
    parameter int MAX_KEYWORD_BYTES = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] source_byte
    input  logic [0:0]   s_tuser,   // [0] command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // start_pos, token_length, keyword_index, punct_code,
                                    // number_value, char_value, error_code, zero pad
    output logic [3:0]   m_tuser,   // [3:0] token_kind
    output logic         m_tlast    // last_of_run
);

    logic                 full;
    logic                 in_fire;
    logic                 push;
    logic                 pop;
    logic                 head_valid;
    stl_pkg::stl_record_t push_rec;
    stl_pkg::stl_record_t head_rec;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    stl_front #(
        .POS_WIDTH         (POS_WIDTH),
        .KEYWORD_COUNT     (KEYWORD_COUNT),
        .MAX_KEYWORD_BYTES (MAX_KEYWORD_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_cmd   (s_tuser[0]),
        .in_byte  (s_tdata),
        .push     (push),
        .push_rec (push_rec)
    );

    stl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_rec   (push_rec),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    stl_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == stl_pkg::KIND_END) |-> m_tlast)
        else $error("end token not last of its run");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= stl_pkg::KIND_ERROR))
        else $error("token kind out of range");

    a_end_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == stl_pkg::KIND_END) |-> (m_tdata[63:32] == 32'd0))
        else $error("end token with nonzero length");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the streaming source token lexer.
`timescale 1ns / 1ps

module tb;

    // Lexer modes of the predictor
    localparam int MODE_IDLE   = 0;
    localparam int MODE_IDENT  = 1;
    localparam int MODE_NUMBER = 2;
    localparam int MODE_STRING = 3;
    localparam int MODE_OP_ONE = 4;
    localparam int MODE_OP_TWO = 5;

    localparam bit CMD_BYTE = 1'b0;
    localparam bit CMD_END  = 1'b1;

    localparam longint unsigned LEN_CAP  = 64'hFFFF_FFFF;
    localparam longint unsigned POS_CAP  = 64'hFFFF_FFFF;
    localparam longint unsigned NUM_CAP  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int              CYCLE_LIMIT = 400000;
    localparam int              RANDOM_ITEMS = 430;

    typedef struct {
        stl_pkg::stl_result_t r;
        bit                   last;
    } token_t;

    typedef struct {
        bit         cmd;
        logic [7:0] b;
    } src_item_t;

    // Directed row: expected token typed in when has_exp is set
    typedef struct {
        bit         cmd;
        logic [7:0] b;
        bit         has_exp;
        logic [3:0] kind;
        int         start;
        int         len;
        logic [4:0] punct;
        logic       err;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // [7:0] source_byte
    logic [0:0]   s_tuser;   // [0] command
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;   // start_pos, token_length, keyword_index, punct_code,
                             // number_value, char_value, error_code, zero pad
    logic [3:0]   m_tuser;   // [3:0] token_kind
    logic         m_tlast;

    source_token_lexer_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    token_t    token_q[$];
    token_t    step_tokens[$];
    src_item_t src_q[$];
    int        fail_count;
    int        cycle_count;

    // Lexer state mirror
    int              lx_mode;
    logic [7:0]      lx_held;
    longint unsigned lx_pos, lx_begin, lx_count, lx_acc;
    logic [11:0]     lx_cands;
    bit              lx_esc, lx_sink;

    function automatic void lex_clear();
        lx_mode = MODE_IDLE;
        lx_held = '0;
        lx_pos = 0;
        lx_begin = 0;
        lx_count = 0;
        lx_acc = 0;
        lx_cands = '0;
        lx_esc = 1'b0;
        lx_sink = 1'b0;
    endfunction

    function automatic void add_token(logic [3:0] kind, longint unsigned start,
                                      longint unsigned len, int kwi, logic [4:0] punct,
                                      longint unsigned num, logic [7:0] ch, logic err);
        token_t t;
        if (step_tokens.size() >= 3) return;
        t.r.kind  = kind;
        t.r.start = start[31:0];
        t.r.len   = len[31:0];
        t.r.kwi   = kwi[3:0];
        t.r.punct = punct;
        t.r.num   = num[62:0];
        t.r.ch    = ch;
        t.r.err   = err;
        t.last    = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic longint unsigned sat_step(longint unsigned v, longint unsigned cap);
        return (v >= cap) ? cap : v + 1;
    endfunction

    function automatic logic [11:0] narrow_cands(logic [11:0] mask, longint unsigned k,
                                                 logic [7:0] b);
        logic [11:0] r;
        r = '0;
        for (int i = 0; i < stl_pkg::ROM_ENTRIES; i++)
            if (mask[i] && k < stl_pkg::KW_LEN[i] && k < 32 &&
                stl_pkg::KW_TEXT[i][8*(int'(stl_pkg::KW_LEN[i]) - 1 - int'(k)) +: 8] == b)
                r[i] = 1'b1;
        return r;
    endfunction

    function automatic bit is_id_first(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b >= 8'h80;
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic int op_code(logic [7:0] b);
        unique case (b)
            "+": return stl_pkg::P_PLUS;
            "-": return stl_pkg::P_MINUS;
            "*": return stl_pkg::P_STAR;
            "/": return stl_pkg::P_SLASH;
            "=": return stl_pkg::P_ASSIGN;
            "<": return stl_pkg::P_LT;
            ">": return stl_pkg::P_GT;
            default: return -1;
        endcase
    endfunction

    function automatic int sym_code(logic [7:0] b);
        unique case (b)
            "(": return stl_pkg::P_LPAREN;
            ")": return stl_pkg::P_RPAREN;
            "{": return stl_pkg::P_LBRACE;
            "}": return stl_pkg::P_RBRACE;
            ";": return stl_pkg::P_SEMI;
            ",": return stl_pkg::P_COMMA;
            default: return -1;
        endcase
    endfunction

    function automatic void emit_word();
        for (int i = 0; i < stl_pkg::ROM_ENTRIES; i++)
            if (lx_cands[i] && stl_pkg::KW_LEN[i] == lx_count) begin
                add_token(stl_pkg::KIND_KEYWORD, lx_begin, lx_count, i, '0, 0, '0, 1'b0);
                return;
            end
        add_token(stl_pkg::KIND_IDENT, lx_begin, lx_count, 0, '0, 0, '0, 1'b0);
    endfunction

    // Lone held operator byte; a lone '!' is a bad character
    function automatic void emit_held();
        int c;
        c = op_code(lx_held);
        if (c < 0) begin
            add_token(stl_pkg::KIND_ERROR, lx_begin, 1, 0, '0, 0, '0, stl_pkg::ERR_BAD_CHAR);
            lx_sink = 1'b1;
        end else begin
            add_token(stl_pkg::KIND_OP, lx_begin, 1, 0, c[4:0], 0, '0, 1'b0);
        end
    endfunction

    function automatic void split_arrow_slash();
        add_token(stl_pkg::KIND_OP, lx_begin, 1, 0, stl_pkg::P_ASSIGN, 0, '0, 1'b0);
        add_token(stl_pkg::KIND_OP, sat_step(lx_begin, POS_CAP), 1, 0, stl_pkg::P_SLASH, 0,
                  '0, 1'b0);
    endfunction

    function automatic void start_token(logic [7:0] b, longint unsigned p);
        int c;
        lx_mode = MODE_IDLE;
        if (b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D) return;
        if (is_id_first(b)) begin
            lx_mode = MODE_IDENT;
            lx_begin = p;
            lx_count = 1;
            lx_cands = narrow_cands('1, 0, b);
        end else if (is_digit(b)) begin
            lx_mode = MODE_NUMBER;
            lx_begin = p;
            lx_count = 1;
            lx_acc = b - "0";
        end else if (b == "\"") begin
            lx_mode = MODE_STRING;
            lx_begin = p;
            lx_count = 0;
            lx_esc = 1'b0;
        end else if (b == "=" || b == "<" || b == ">" || b == "!") begin
            lx_mode = MODE_OP_ONE;
            lx_held = b;
            lx_begin = p;
        end else if (op_code(b) >= 0) begin
            c = op_code(b);
            add_token(stl_pkg::KIND_OP, p, 1, 0, c[4:0], 0, '0, 1'b0);
        end else if (sym_code(b) >= 0) begin
            c = sym_code(b);
            add_token(stl_pkg::KIND_SYMBOL, p, 1, 0, c[4:0], 0, '0, 1'b0);
        end else begin
            add_token(stl_pkg::KIND_ERROR, p, 1, 0, '0, 0, '0, stl_pkg::ERR_BAD_CHAR);
            lx_sink = 1'b1;
        end
    endfunction

    function automatic void lex_byte(logic [7:0] b, longint unsigned p);
        int c;
        longint unsigned d;
        c = -1;
        case (lx_mode)
            MODE_IDENT: begin
                if (is_id_first(b) || is_digit(b) || b == ".") begin
                    lx_cands = narrow_cands(lx_cands, lx_count, b);
                    lx_count = sat_step(lx_count, LEN_CAP);
                    return;
                end
                emit_word();
                start_token(b, p);
            end
            MODE_NUMBER: begin
                if (is_digit(b)) begin
                    d = b - "0";
                    if (lx_acc > (NUM_CAP - d) / 10) lx_acc = NUM_CAP;
                    else lx_acc = lx_acc * 10 + d;
                    lx_count = sat_step(lx_count, LEN_CAP);
                    return;
                end
                add_token(stl_pkg::KIND_NUMBER, lx_begin, lx_count, 0, '0, lx_acc, '0, 1'b0);
                start_token(b, p);
            end
            MODE_STRING: begin
                if (lx_esc) begin
                    lx_esc = 1'b0;
                    add_token(stl_pkg::KIND_CHAR, p - 1, 1, 0, '0, 0,
                              (b == "n") ? 8'h0A : ((b == "t") ? 8'h09 : b), 1'b0);
                    lx_count = sat_step(lx_count, LEN_CAP);
                end else if (b == "\"") begin
                    add_token(stl_pkg::KIND_CLOSE, lx_begin, lx_count, 0, '0, 0, '0, 1'b0);
                    lx_mode = MODE_IDLE;
                end else if (b == "\\") begin
                    lx_esc = 1'b1;
                end else begin
                    add_token(stl_pkg::KIND_CHAR, p, 1, 0, '0, 0, b, 1'b0);
                    lx_count = sat_step(lx_count, LEN_CAP);
                end
            end
            MODE_OP_ONE: begin
                if (lx_held == "=" && b == "/") begin
                    lx_mode = MODE_OP_TWO;
                    return;
                end
                if (b == "=") begin
                    if (lx_held == "=") c = stl_pkg::P_EQ_EQ;
                    else if (lx_held == "!") c = stl_pkg::P_BANG_EQ;
                    else if (lx_held == "<") c = stl_pkg::P_LE;
                    else if (lx_held == ">") c = stl_pkg::P_GE;
                end else if (b == ">" && lx_held == "=") begin
                    c = stl_pkg::P_ARROW;
                end
                if (c >= 0) begin
                    add_token(stl_pkg::KIND_OP, lx_begin, 2, 0, c[4:0], 0, '0, 1'b0);
                    lx_mode = MODE_IDLE;
                    return;
                end
                emit_held();
                lx_mode = MODE_IDLE;
                if (!lx_sink) start_token(b, p);
            end
            MODE_OP_TWO: begin
                if (b == "=") begin
                    add_token(stl_pkg::KIND_OP, lx_begin, 3, 0, stl_pkg::P_NEQ_SLASH, 0, '0,
                              1'b0);
                    lx_mode = MODE_IDLE;
                    return;
                end
                split_arrow_slash();
                start_token(b, p);
            end
            default: start_token(b, p);
        endcase
    endfunction

    // Tokens caused by one accepted transaction, left in step_tokens
    function automatic void lex_step(bit cmd, logic [7:0] b);
        longint unsigned p;
        step_tokens.delete();
        if (cmd == CMD_END || b == 8'h00) begin
            if (!lx_sink) begin
                case (lx_mode)
                    MODE_IDENT:  emit_word();
                    MODE_NUMBER: add_token(stl_pkg::KIND_NUMBER, lx_begin, lx_count, 0, '0,
                                           lx_acc, '0, 1'b0);
                    MODE_STRING: add_token(stl_pkg::KIND_ERROR, lx_begin, lx_count, 0, '0, 0,
                                           '0, stl_pkg::ERR_UNTERMINATED);
                    MODE_OP_ONE: emit_held();
                    MODE_OP_TWO: split_arrow_slash();
                    default: ;
                endcase
            end
            add_token(stl_pkg::KIND_END, lx_pos, 0, 0, '0, 0, '0, 1'b0);
            lex_clear();
        end else begin
            p = lx_pos;
            lx_pos = sat_step(lx_pos, POS_CAP);
            if (!lx_sink) lex_byte(b, p);
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    endfunction

    // Source text builders for the random part
    function automatic void push_byte(logic [7:0] b);
        src_item_t it;
        it.cmd = CMD_BYTE;
        it.b = b;
        src_q.push_back(it);
    endfunction

    function automatic void push_end();
        src_item_t it;
        it.cmd = CMD_END;
        it.b = 8'($urandom);
        src_q.push_back(it);
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endfunction

    function automatic void build_random();
        string ops[$];
        int sel, n, k;
        ops = '{"=/=", "==", "!=", "<=", ">=", "=>", "+", "-", "*", "/", "=", "<", ">",
                "(", ")", "{", "}", ";", ",", "=/", "=/x", "!"};
        while (src_q.size() < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) begin
                // keyword, sometimes cut short or extended
                k = $urandom_range(0, stl_pkg::ROM_ENTRIES - 1);
                n = stl_pkg::KW_LEN[k];
                if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
                for (int j = 0; j < n; j++)
                    push_byte(stl_pkg::KW_TEXT[k][8*(int'(stl_pkg::KW_LEN[k]) - 1 - j) +: 8]);
                if ($urandom_range(0, 4) == 0) push_byte(pick("a9._"));
            end else if (sel < 27) begin
                push_byte(pick("abzAZ_q"));
                n = $urandom_range(0, 5);
                for (int j = 0; j < n; j++)
                    push_byte($urandom_range(0, 1) ? pick("az09._QZ") :
                              8'($urandom_range(8'h80, 8'hFF)));
            end else if (sel < 40) begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(19, 24) : $urandom_range(1, 4);
                for (int j = 0; j < n; j++)
                    push_byte(($urandom_range(0, 1) ? "9" : pick("0123456789")));
            end else if (sel < 55) begin
                push_byte("\"");
                n = $urandom_range(0, 5);
                for (int j = 0; j < n; j++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        push_byte("\\");
                        push_byte($urandom_range(0, 1) ? pick("nt\"\\x") :
                                  8'($urandom_range(1, 255)));
                    end else begin
                        push_byte(8'($urandom_range(1, 255)) == "\"" ? "a" :
                                  8'($urandom_range(1, 255)));
                    end
                end
                if ($urandom_range(0, 7) != 0) push_byte("\"");
            end else if (sel < 75) begin
                push_text(ops[$urandom_range(0, ops.size() - 1)]);
            end else if (sel < 88) begin
                push_byte(pick(" \t\r\n"));
            end else if (sel < 92) begin
                // any nonzero byte, bad ones included
                push_byte(8'($urandom_range(1, 255)));
            end else if (sel < 97) begin
                push_end();
            end else begin
                push_byte(8'h00);
            end
        end
        push_end();
    endfunction

    // Monitor: check each accepted result against the oldest expectation
    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        token_t t;
        if (aresetn && m_tvalid && m_tready) begin
            if (token_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual kind %0d",
                         $time, m_tuser);
                fail_count++;
            end else begin
                t = token_q.pop_front();
                check_field("token_kind",    t.r.kind,  m_tuser);
                check_field("start_pos",     t.r.start, m_tdata[31:0]);
                check_field("token_length",  t.r.len,   m_tdata[63:32]);
                check_field("keyword_index", t.r.kwi,   m_tdata[67:64]);
                check_field("punct_code",    t.r.punct, m_tdata[72:68]);
                check_field("number_value",  t.r.num,   m_tdata[135:73]);
                check_field("char_value",    t.r.ch,    m_tdata[143:136]);
                check_field("error_code",    t.r.err,   m_tdata[144]);
                check_field("last_of_run",   t.last,    m_tlast);
            end
        end
    end

    // Sink stalls: mostly short, a few long, with calm stretches
    int sink_hold;
    int sink_calm;
    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_hold <= 0;
            sink_calm <= 0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready <= 1'b0;
        end else if (sink_calm > 0) begin
            sink_calm <= sink_calm - 1;
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            m_tready <= 1'b1;
            if (r < 3) sink_calm <= $urandom_range(30, 80);
            else if (r < 6) sink_hold <= $urandom_range(10, 30);
            else if (r < 30) sink_hold <= $urandom_range(0, 2);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sends one transaction; the caller records the tokens it must cause
    task automatic send_item(bit cmd, logic [7:0] b, bit calm);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (!calm) begin
            if (r < 4) gap = $urandom_range(10, 30);
            else if (r < 30) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    dir_row_t dir_rows[$];

    function automatic dir_row_t row(bit cmd, logic [7:0] b, bit has_exp = 1'b0,
                                     logic [3:0] kind = stl_pkg::KIND_IDENT, int start = 0,
                                     int len = 0, logic [4:0] punct = '0, logic err = 1'b0);
        dir_row_t d;
        d.cmd = cmd; d.b = b; d.has_exp = has_exp; d.kind = kind;
        d.start = start; d.len = len; d.punct = punct; d.err = err;
        return d;
    endfunction

    initial begin
        token_t t;
        bit calm;
        fail_count = 0;
        cycle_count = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        lex_clear();

        dir_rows = '{
            row(CMD_END,  8'h00, 1, stl_pkg::KIND_END, 0, 0),           // end at reset
            row(CMD_BYTE, "+",   1, stl_pkg::KIND_OP, 0, 1, stl_pkg::P_PLUS),
            row(CMD_BYTE, ",",   1, stl_pkg::KIND_SYMBOL, 1, 1, stl_pkg::P_COMMA),
            row(CMD_BYTE, "#",   1, stl_pkg::KIND_ERROR, 2, 1, '0,
                stl_pkg::ERR_BAD_CHAR),                                 // bad byte
            row(CMD_BYTE, 8'hFF),                                       // swallowed
            row(CMD_BYTE, 8'h00, 1, stl_pkg::KIND_END, 4, 0),           // zero byte ends
            row(CMD_BYTE, "="), row(CMD_BYTE, "/"), row(CMD_BYTE, "x"), // '=' '/' split
            row(CMD_BYTE, "!"), row(CMD_BYTE, "q"),                     // lone '!'
            row(CMD_END,  8'hFF),
            row(CMD_BYTE, "\""), row(CMD_BYTE, "\\"), row(CMD_BYTE, "n"),
            row(CMD_BYTE, 8'h80), row(CMD_BYTE, "\""),
            row(CMD_BYTE, "\""), row(CMD_BYTE, "\\"),
            row(CMD_END,  8'h55),                                       // open string
            row(CMD_BYTE, "9"), row(CMD_BYTE, "<"), row(CMD_BYTE, "="),
            row(CMD_BYTE, "Z"), row(CMD_END, 8'hAA)
        };
        build_random();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].cmd, dir_rows[i].b, 1'b0);
            lex_step(dir_rows[i].cmd, dir_rows[i].b);
            if (dir_rows[i].has_exp) begin
                t.r = stl_pkg::mk_res(dir_rows[i].kind, dir_rows[i].start, dir_rows[i].len,
                                      '0, dir_rows[i].punct, '0, '0, dir_rows[i].err);
                t.last = 1'b1;
                token_q.push_back(t);
            end else begin
                foreach (step_tokens[j]) token_q.push_back(step_tokens[j]);
            end
        end

        calm = 1'b0;
        foreach (src_q[i]) begin
            if (i % 60 == 0) calm = ($urandom_range(0, 2) == 0);
            send_item(src_q[i].cmd, src_q[i].b, calm);
            lex_step(src_q[i].cmd, src_q[i].b);
            foreach (step_tokens[j]) token_q.push_back(step_tokens[j]);
        end
        s_tvalid <= 1'b0;

        while (token_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
